// ===== design/phs_pkg.sv =====
// ----------------------------------------------------------------------------
// phs_pkg: shared types and constants of the pH stability window
// Widths, record formats, configuration register codes, the state type of
// the window engine and the reciprocal table used for the average.
// ----------------------------------------------------------------------------
package phs_pkg;

  // Window geometry; every derived width follows from the depth.
  localparam int WINDOW_DEPTH = 16;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = 17 + IDX_W;
  localparam int SQ_W         = 31 + IDX_W;
  localparam int LHS_W        = 32 + 2 * IDX_W;
  localparam int BND_W        = 13 + IDX_W;

  // Field widths.
  localparam int VAL_W      = 16;
  localparam int FAIL_W     = 8;
  localparam int THR_W      = 12;
  localparam int SPAN_W     = 5;
  localparam int FILL_OUT_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Average datapath: at most SPAN_MAX readings are summed.
  localparam int SPAN_MAX = 16;
  localparam int ACC_W    = 21;
  localparam int MAG_W    = 20;
  localparam int RCP_SH   = 25;
  localparam int RCP_W    = 26;
  localparam int DPROD_W  = MAG_W + RCP_W;

  // Depth of the queue between the front end and the window engine.
  localparam int QUEUE_DEPTH = 2;

  // Reciprocals ceil(2^25 / k); exact floor division for magnitudes below 2^20.
  localparam logic [RCP_W-1:0] RECIP_TBL [SPAN_MAX+1] = '{
    26'd33554432, 26'd33554432, 26'd16777216, 26'd11184811, 26'd8388608,
    26'd6710887,  26'd5592406,  26'd4793491,  26'd4194304,  26'd3728271,
    26'd3355444,  26'd3050403,  26'd2796203,  26'd2581111,  26'd2396746,
    26'd2236963,  26'd2097152
  };

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_THR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_RUN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_SPAN   = 3'd5;

  // Configuration reset values.
  localparam logic [VAL_W-1:0]  RANGE_LOW_RST  = 16'd0;
  localparam logic [VAL_W-1:0]  RANGE_HIGH_RST = 16'd1400;
  localparam logic [FAIL_W-1:0] ERR_LIMIT_RST  = 8'd5;
  localparam logic [THR_W-1:0]  STABLE_THR_RST = 12'd5;
  localparam logic [SPAN_W-1:0] AVG_SPAN_RST   = 5'd16;

  typedef struct packed {
    logic signed [VAL_W-1:0] range_low;
    logic signed [VAL_W-1:0] range_high;
    logic [FAIL_W-1:0]       error_limit;
    logic [THR_W-1:0]        stable_threshold;
    logic                    free_running;
    logic [SPAN_W-1:0]       average_span;
  } cfg_t;

  // One classified reading on its way to the window engine.
  typedef struct packed {
    logic signed [VAL_W-1:0] reading;
    logic                    took;
    logic                    alive;
    logic [FAIL_W-1:0]       fail_run;
  } item_t;

  // One result word.
  typedef struct packed {
    logic                    ready_res;
    logic                    accepted;
    logic                    stable;
    logic signed [VAL_W-1:0] last_value;
    logic signed [VAL_W-1:0] recent_average;
    logic [FAIL_W-1:0]       failure_count;
    logic [FILL_OUT_W-1:0]   filled;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_OLD,
    S_SUB_OLD,
    S_SQ_OLD,
    S_WR_NEW,
    S_SQ_NEW,
    S_SQS,
    S_BND,
    S_CMP,
    S_AVG,
    S_DIV,
    S_NEG,
    S_OUT
  } back_state_t;

endpackage

// ===== design/phs_ram.sv =====
// ----------------------------------------------------------------------------
// phs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module phs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/phs_fifo.sv =====
// ----------------------------------------------------------------------------
// phs_fifo: short queue of classified readings
// Decouples the front end from the window engine so each can stall alone.
// ----------------------------------------------------------------------------
module phs_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  phs_pkg::item_t push_word,
  output logic           full,
  input  logic           pop,
  output phs_pkg::item_t pop_word,
  output logic           empty
);

  localparam int Q_IDX_W = $clog2(phs_pkg::QUEUE_DEPTH);
  localparam int Q_CNT_W = $clog2(phs_pkg::QUEUE_DEPTH + 1);

  phs_pkg::item_t     q_mem_r [phs_pkg::QUEUE_DEPTH];
  logic [Q_IDX_W-1:0] wp_r, wp_nxt;
  logic [Q_IDX_W-1:0] rp_r, rp_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  // Pointer and occupancy update.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == Q_IDX_W'(phs_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == Q_IDX_W'(phs_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= push_word;
    end
  end

  assign pop_word = q_mem_r[rp_r];
  assign full     = (cnt_r == Q_CNT_W'(phs_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);

endmodule

// ===== design/phs_front.sv =====
// ----------------------------------------------------------------------------
// phs_front: reading classifier
// Range-checks each word unless free running, keeps the failure run and
// the ready flag, and queues the classified reading for the window engine.
// ----------------------------------------------------------------------------
module phs_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  phs_pkg::cfg_t                  cfg,
  input  logic                           in_push,
  input  logic signed [phs_pkg::VAL_W-1:0] in_reading,
  input  logic                           in_read_ok,
  output logic                           in_full,
  input  logic                           q_full,
  output logic                           q_push,
  output phs_pkg::item_t                 q_word
);

  logic [phs_pkg::FAIL_W-1:0] fail_r, fail_nxt;
  logic                       alive_r, alive_nxt;
  logic                       took;
  logic                       in_range;

  assign q_push  = in_push && !q_full;
  assign in_full = q_full;

  // Classification of the word being accepted.
  always_comb begin
    fail_nxt  = fail_r;
    alive_nxt = alive_r;
    took      = 1'b0;
    in_range  = (in_reading >= cfg.range_low) && (in_reading <= cfg.range_high);
    if (q_push && alive_r) begin
      if (cfg.free_running) begin
        if (in_read_ok) begin
          took     = 1'b1;
          fail_nxt = '0;
        end
      end else if (in_read_ok && in_range) begin
        took     = 1'b1;
        fail_nxt = '0;
      end else begin
        // The run saturates, so a limit at full scale keeps the sensor ready.
        if (fail_r != '1) begin
          fail_nxt = fail_r + 1'b1;
        end
        if (fail_nxt > cfg.error_limit) begin
          alive_nxt = 1'b0;
        end
      end
    end
    q_word.reading  = in_reading;
    q_word.took     = took;
    q_word.alive    = alive_nxt;
    q_word.fail_run = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_r  <= '0;
      alive_r <= 1'b1;
    end else begin
      fail_r  <= fail_nxt;
      alive_r <= alive_nxt;
    end
  end

endmodule

// ===== design/phs_back.sv =====
// ----------------------------------------------------------------------------
// phs_back: window engine
// Stores good readings in the ring window, keeps the running sums, decides
// stability, averages the most recent readings and holds the result word.
// ----------------------------------------------------------------------------
module phs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  phs_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  phs_pkg::item_t q_word,
  output logic          q_pop,
  output phs_pkg::res_t out_res,
  output logic          out_empty,
  input  logic          out_pop
);

  localparam int IDX_W   = phs_pkg::IDX_W;
  localparam int CNT_W   = phs_pkg::CNT_W;
  localparam int SUM_W   = phs_pkg::SUM_W;
  localparam int SQ_W    = phs_pkg::SQ_W;
  localparam int LHS_W   = phs_pkg::LHS_W;
  localparam int BND_W   = phs_pkg::BND_W;
  localparam int VAL_W   = phs_pkg::VAL_W;
  localparam int ACC_W   = phs_pkg::ACC_W;
  localparam int MAG_W   = phs_pkg::MAG_W;
  localparam int SPAN_W  = phs_pkg::SPAN_W;
  localparam int DPROD_W = phs_pkg::DPROD_W;
  localparam int KCMP_W  = CNT_W + SPAN_W;

  function automatic logic [IDX_W-1:0] prev_pos(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(phs_pkg::WINDOW_DEPTH - 1) : p - 1'b1;
  endfunction

  phs_pkg::back_state_t state_r, state_nxt;

  // Window state.
  logic [IDX_W-1:0]        wp_r, wp_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;

  // Working registers.
  phs_pkg::item_t          cur_r, cur_nxt;
  logic [31:0]             prod_r, prod_nxt;
  logic signed [LHS_W-1:0] m_r, m_nxt;
  logic signed [LHS_W-1:0] lhs_r, lhs_nxt;
  logic [BND_W-1:0]        b_r, b_nxt;
  logic signed [LHS_W-1:0] b2_r, b2_nxt;
  logic                    stable_r, stable_nxt;
  logic [IDX_W-1:0]        rp_r, rp_nxt;
  logic [SPAN_W-1:0]       k_r, k_nxt;
  logic [SPAN_W-1:0]       issued_r, issued_nxt;
  logic                    pend_r, pend_nxt;
  logic                    first_r, first_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [VAL_W-1:0]        last_r, last_nxt;
  logic                    sign_r, sign_nxt;
  logic [DPROD_W-1:0]      dprod_r, dprod_nxt;
  logic [VAL_W-1:0]        avg_r, avg_nxt;
  phs_pkg::res_t           res_r, res_nxt;
  logic                    res_valid_r, res_valid_nxt;

  // Combinational helpers.
  logic signed [VAL_W-1:0] mul_a;
  logic signed [31:0]      mul_ext;
  logic [ACC_W-1:0]        mag_full;
  logic [MAG_W-1:0]        quot;
  logic [SPAN_W-1:0]       span_eff;
  logic                    res_load;

  // Window RAM ports.
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [VAL_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [VAL_W-1:0]        ram_rdata;

  phs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (phs_pkg::WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and datapath.
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    cur_nxt       = cur_r;
    prod_nxt      = prod_r;
    m_nxt         = m_r;
    lhs_nxt       = lhs_r;
    b_nxt         = b_r;
    b2_nxt        = b2_r;
    stable_nxt    = stable_r;
    rp_nxt        = rp_r;
    k_nxt         = k_r;
    issued_nxt    = issued_r;
    pend_nxt      = pend_r;
    first_nxt     = first_r;
    acc_nxt       = acc_r;
    last_nxt      = last_r;
    sign_nxt      = sign_r;
    dprod_nxt     = dprod_r;
    avg_nxt       = avg_r;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    res_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = wp_r;
    ram_wdata     = cur_r.reading;
    ram_raddr     = rp_r;
    mul_a         = cur_r.reading;
    span_eff      = (cfg.average_span == '0) ? SPAN_W'(1) : cfg.average_span;
    mag_full      = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    quot          = dprod_r[phs_pkg::RCP_SH+MAG_W-1:phs_pkg::RCP_SH];
    mul_ext       = 32'(mul_a);

    unique case (state_r)
      // Take the next classified reading.
      phs_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_word;
          if (!q_word.took) begin
            state_nxt = phs_pkg::S_SQS;
          end else if (fill_r == CNT_W'(phs_pkg::WINDOW_DEPTH)) begin
            state_nxt = phs_pkg::S_RD_OLD;
          end else begin
            state_nxt = phs_pkg::S_WR_NEW;
          end
        end
      end
      // Fetch the oldest entry, which the new reading replaces.
      phs_pkg::S_RD_OLD: begin
        ram_raddr = wp_r;
        state_nxt = phs_pkg::S_SUB_OLD;
      end
      phs_pkg::S_SUB_OLD: begin
        mul_a     = $signed(ram_rdata);
        mul_ext   = 32'(mul_a);
        sum_nxt   = sum_r - SUM_W'($signed(ram_rdata));
        prod_nxt  = $unsigned(mul_ext * mul_ext);
        state_nxt = phs_pkg::S_SQ_OLD;
      end
      phs_pkg::S_SQ_OLD: begin
        sq_nxt    = sq_r - SQ_W'(prod_r);
        state_nxt = phs_pkg::S_WR_NEW;
      end
      // Store the new reading and advance the ring.
      phs_pkg::S_WR_NEW: begin
        ram_we    = 1'b1;
        sum_nxt   = sum_r + SUM_W'(cur_r.reading);
        prod_nxt  = $unsigned(mul_ext * mul_ext);
        wp_nxt    = (wp_r == IDX_W'(phs_pkg::WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        if (fill_r != CNT_W'(phs_pkg::WINDOW_DEPTH)) begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = phs_pkg::S_SQ_NEW;
      end
      phs_pkg::S_SQ_NEW: begin
        sq_nxt    = sq_r + SQ_W'(prod_r);
        state_nxt = phs_pkg::S_SQS;
      end
      // Spread of the window: D*sumsq - sum^2 against (D*thr)^2.
      phs_pkg::S_SQS: begin
        m_nxt     = LHS_W'(sum_r) * LHS_W'(sum_r);
        lhs_nxt   = $signed(LHS_W'(sq_r) * LHS_W'(phs_pkg::WINDOW_DEPTH));
        b_nxt     = BND_W'(cfg.stable_threshold) * BND_W'(phs_pkg::WINDOW_DEPTH);
        state_nxt = phs_pkg::S_BND;
      end
      phs_pkg::S_BND: begin
        b2_nxt    = $signed(LHS_W'(b_r) * LHS_W'(b_r));
        lhs_nxt   = lhs_r - m_r;
        state_nxt = phs_pkg::S_CMP;
      end
      // Stability decision and set-up of the averaging pass.
      phs_pkg::S_CMP: begin
        stable_nxt = (fill_r == CNT_W'(phs_pkg::WINDOW_DEPTH)) && (lhs_r < b2_r);
        k_nxt      = (KCMP_W'(span_eff) > KCMP_W'(fill_r)) ? SPAN_W'(fill_r) : span_eff;
        rp_nxt     = prev_pos(wp_r);
        issued_nxt = '0;
        pend_nxt   = 1'b0;
        first_nxt  = 1'b1;
        acc_nxt    = '0;
        if (fill_r == '0) begin
          avg_nxt   = '0;
          last_nxt  = '0;
          state_nxt = phs_pkg::S_OUT;
        end else begin
          state_nxt = phs_pkg::S_AVG;
        end
      end
      // Walk back from the newest entry, one read issued per cycle.
      phs_pkg::S_AVG: begin
        ram_raddr = rp_r;
        if (issued_r != k_r) begin
          rp_nxt     = prev_pos(rp_r);
          issued_nxt = issued_r + 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          acc_nxt = acc_r + ACC_W'($signed(ram_rdata));
          if (first_r) begin
            last_nxt  = ram_rdata;
            first_nxt = 1'b0;
          end
        end
        if ((issued_r == k_r) && !pend_r) begin
          state_nxt = phs_pkg::S_DIV;
        end
      end
      // Divide the magnitude by k through the reciprocal table.
      phs_pkg::S_DIV: begin
        sign_nxt  = acc_r[ACC_W-1];
        dprod_nxt = DPROD_W'(mag_full[MAG_W-1:0]) * DPROD_W'(phs_pkg::RECIP_TBL[k_r]);
        state_nxt = phs_pkg::S_NEG;
      end
      phs_pkg::S_NEG: begin
        avg_nxt   = sign_r ? VAL_W'(-quot) : VAL_W'(quot);
        state_nxt = phs_pkg::S_OUT;
      end
      // Hand the result word over once the output register is free.
      phs_pkg::S_OUT: begin
        if (!res_valid_r || out_pop) begin
          res_load               = 1'b1;
          res_nxt.ready_res      = cur_r.alive;
          res_nxt.accepted       = cur_r.took;
          res_nxt.stable         = stable_r;
          res_nxt.last_value     = last_r;
          res_nxt.recent_average = avg_r;
          res_nxt.failure_count  = cur_r.fail_run;
          res_nxt.filled         = phs_pkg::FILL_OUT_W'(fill_r);
          state_nxt              = phs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = phs_pkg::S_IDLE;
      end
    endcase

    res_valid_nxt = (res_valid_r && !out_pop) || res_load;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= phs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Window state and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      issued_r    <= '0;
      pend_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      issued_r    <= issued_nxt;
      pend_r      <= pend_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    prod_r   <= prod_nxt;
    m_r      <= m_nxt;
    lhs_r    <= lhs_nxt;
    b_r      <= b_nxt;
    b2_r     <= b2_nxt;
    stable_r <= stable_nxt;
    rp_r     <= rp_nxt;
    k_r      <= k_nxt;
    first_r  <= first_nxt;
    acc_r    <= acc_nxt;
    last_r   <= last_nxt;
    sign_r   <= sign_nxt;
    dprod_r  <= dprod_nxt;
    avg_r    <= avg_nxt;
    res_r    <= res_nxt;
  end

  assign out_res   = res_r;
  assign out_empty = !res_valid_r;

  // Checks on the engine's own bookkeeping.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(phs_pkg::WINDOW_DEPTH))
    else $error("window fill level beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_stable_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == phs_pkg::S_OUT && stable_r) |-> (fill_r == CNT_W'(phs_pkg::WINDOW_DEPTH)))
    else $error("stable reported on a window that is not full");

  a_avg_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == phs_pkg::S_AVG) |-> (issued_r <= k_r))
    else $error("averaging pass read more entries than its span");

  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == phs_pkg::S_OUT && res_valid_r && !out_pop) |=> (state_r == phs_pkg::S_OUT))
    else $error("result word overwritten before it was taken");

endmodule

// ===== design/ph_sample_stability_window.sv =====
// ----------------------------------------------------------------------------
// ph_sample_stability_window: pH reading stability window
// Classifies pH readings, keeps a ring window of good ones and reports
// stability, the newest reading and the average of the most recent ones.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Words carried
//   in_       push / full            reading, read_ok
//   out_      empty / pop            ready_res, accepted, stable, last_value,
//                                    recent_average, failure_count, filled
//   cfg_      valid / ready          index, data (ready is always high)
//
// The window engine handles one word at a time: the window update for a stored
// word, the stability check, the averaging pass and the result register; the
// averaging pass covers k = min(span, filled) entries and reads one window
// entry per cycle from the window RAM.
// A two-entry queue lets the front end keep accepting words meanwhile.
// Reset is synchronous and needs no clearing pass; the window RAM is never
// read before it is written. A result word that is not popped holds the
// engine in its last step, and the queue then fills and raises full.
// ----------------------------------------------------------------------------
module ph_sample_stability_window (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [phs_pkg::VAL_W-1:0]    in_reading,
  input  logic                                in_read_ok,
  // Result channel
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic                                out_ready_res,
  output logic                                out_accepted,
  output logic                                out_stable,
  output logic signed [phs_pkg::VAL_W-1:0]    out_last_value,
  output logic signed [phs_pkg::VAL_W-1:0]    out_recent_average,
  output logic [phs_pkg::FAIL_W-1:0]          out_failure_count,
  output logic [phs_pkg::FILL_OUT_W-1:0]      out_filled,
  // Configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [phs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [phs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  phs_pkg::cfg_t  cfg_r, cfg_nxt;
  phs_pkg::item_t q_in_word;
  phs_pkg::item_t q_out_word;
  phs_pkg::res_t  res;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  assign cfg_ready = 1'b1;

  // Configuration register decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        phs_pkg::CFG_RANGE_LOW:  cfg_nxt.range_low        = $signed(cfg_data);
        phs_pkg::CFG_RANGE_HIGH: cfg_nxt.range_high       = $signed(cfg_data);
        phs_pkg::CFG_ERR_LIMIT:  cfg_nxt.error_limit      = cfg_data[phs_pkg::FAIL_W-1:0];
        phs_pkg::CFG_STABLE_THR: cfg_nxt.stable_threshold = cfg_data[phs_pkg::THR_W-1:0];
        phs_pkg::CFG_FREE_RUN:   cfg_nxt.free_running     = cfg_data[0];
        phs_pkg::CFG_AVG_SPAN:   cfg_nxt.average_span     = cfg_data[phs_pkg::SPAN_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_low        <= $signed(phs_pkg::RANGE_LOW_RST);
      cfg_r.range_high       <= $signed(phs_pkg::RANGE_HIGH_RST);
      cfg_r.error_limit      <= phs_pkg::ERR_LIMIT_RST;
      cfg_r.stable_threshold <= phs_pkg::STABLE_THR_RST;
      cfg_r.free_running     <= 1'b0;
      cfg_r.average_span     <= phs_pkg::AVG_SPAN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  phs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_reading (in_reading),
    .in_read_ok (in_read_ok),
    .in_full    (in_full),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_word     (q_in_word)
  );

  phs_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_in_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (q_out_word),
    .empty     (q_empty)
  );

  phs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_word    (q_out_word),
    .q_pop     (q_pop),
    .out_res   (res),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  assign out_ready_res      = res.ready_res;
  assign out_accepted       = res.accepted;
  assign out_stable         = res.stable;
  assign out_last_value     = res.last_value;
  assign out_recent_average = res.recent_average;
  assign out_failure_count  = res.failure_count;
  assign out_filled         = res.filled;

endmodule
